// File: rtl/crsh_pkg.sv
// shared types, constants and helpers of the closest ray/sphere hit block
package crsh_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int CSR_ADDR_W        = 5;

   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
   localparam logic [2:0] REG_DIR_X       = 3'd3;
   localparam logic [2:0] REG_DIR_Y       = 3'd4;
   localparam logic [2:0] REG_DIR_Z       = 3'd5;
   localparam logic [2:0] REG_MAX_DIST    = 3'd6;
   localparam logic [2:0] REG_RAY_PRESENT = 3'd7;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic signed [17:0] dir_z;
      logic [30:0]        max_distance;
      logic               ray_present;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] radius;
      logic               last_object;
   } item_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] spawn_x;
      logic signed [31:0] spawn_y;
      logic signed [31:0] spawn_z;
      logic [30:0]        hit_distance;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_CMP, ST_SQRT, ST_ROOT, ST_PICK, ST_FIN
   } back_state_type;

   // order of work on the shared multiplier
   typedef enum logic [3:0] {
      STEP_BX, STEP_BY, STEP_BZ, STEP_OX, STEP_OY, STEP_OZ, STEP_RR,
      STEP_BHH, STEP_BHL, STEP_BLL, STEP_FX, STEP_FY, STEP_FZ, STEP_DRAIN
   } step_type;

   function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
      logic signed [69:0] hi_lim;
      logic signed [69:0] lo_lim;
      hi_lim = 70'sd2147483647;
      lo_lim = -70'sd2147483648;
      if (v > hi_lim) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo_lim) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// File: rtl/closest_ray_sphere_hit_core.sv
// Closest ray/sphere hit search, top level with register port. Objects stream in
// as center and scale; the ray lives in registers. The back end works on one object
// at a time: each object runs a 14-step sequence on one shared 34x34 multiplier,
// and one that passes the discriminant test then feeds a square root that retires
// two radicand bits per cycle (HW-bit radicand, HW = max(2*FRAC_BITS+68, 106) + 2).
// With ray_present clear an object skips both. The last object of a search also
// waits in its final state while the previous result is still held. A two-item
// queue lets the input side keep taking objects while the back end works, and a
// result register holds the answer of the last object until it is taken.
module closest_ray_sphere_hit_core #(
   parameter int FRAC_BITS = crsh_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // center_x, center_y, center_z, scale_x, scale_y, scale_z
   input  logic [191:0]                  req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // spawn_x, spawn_y, spawn_z, hit_distance, zero pad
   output logic [127:0]                  rsp_tdata,
   // hit
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [crsh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import crsh_pkg::*;

   cfg_type    cfg_ff;
   item_type   f_item, q_out;
   result_type result;
   logic       f_push, q_not_full, q_not_empty, q_pop;
   logic [2:0] reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
         cfg_ff.origin_z     <= '0;
         cfg_ff.dir_x        <= '0;
         cfg_ff.dir_y        <= '0;
         cfg_ff.dir_z        <= 18'sd1 <<< FRAC_BITS;
         cfg_ff.max_distance <= 31'd5 << FRAC_BITS;
         cfg_ff.ray_present  <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_ORIGIN_X:    cfg_ff.origin_x     <= csr_pwdata;
            REG_ORIGIN_Y:    cfg_ff.origin_y     <= csr_pwdata;
            REG_ORIGIN_Z:    cfg_ff.origin_z     <= csr_pwdata;
            REG_DIR_X:       cfg_ff.dir_x        <= csr_pwdata[17:0];
            REG_DIR_Y:       cfg_ff.dir_y        <= csr_pwdata[17:0];
            REG_DIR_Z:       cfg_ff.dir_z        <= csr_pwdata[17:0];
            REG_MAX_DIST:    cfg_ff.max_distance <= csr_pwdata[30:0];
            REG_RAY_PRESENT: cfg_ff.ray_present  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ORIGIN_X:    csr_prdata = cfg_ff.origin_x;
         REG_ORIGIN_Y:    csr_prdata = cfg_ff.origin_y;
         REG_ORIGIN_Z:    csr_prdata = cfg_ff.origin_z;
         REG_DIR_X:       csr_prdata = 32'(cfg_ff.dir_x);
         REG_DIR_Y:       csr_prdata = 32'(cfg_ff.dir_y);
         REG_DIR_Z:       csr_prdata = 32'(cfg_ff.dir_z);
         REG_MAX_DIST:    csr_prdata = {1'b0, cfg_ff.max_distance};
         REG_RAY_PRESENT: csr_prdata = {31'b0, cfg_ff.ray_present};
         default:         csr_prdata = '0;
      endcase
   end

   crsh_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_ready    (q_not_full),
      .q_push     (f_push),
      .q_item     (f_item)
   );

   crsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_out)
   );

   crsh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_not_empty),
      .q_item     (q_out),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {1'b0, result.hit_distance, result.spawn_z,
                       result.spawn_y, result.spawn_x};
   assign rsp_tuser = result.hit;

endmodule

// File: rtl/crsh_front.sv
// front end: takes object items and works out the sphere radius
module crsh_front #(
   parameter int FRAC_BITS = crsh_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [191:0]        req_tdata,
   input  logic                req_tlast,
   input  logic                q_ready,
   output logic                q_push,
   output crsh_pkg::item_type  q_item
);
   import crsh_pkg::*;

   localparam logic signed [31:0] HALF_UNIT = 32'sd1 <<< (FRAC_BITS - 1);

   logic signed [31:0] sx, sy, sz, rmax;

   always_comb begin
      sx = req_tdata[127:96];
      sy = req_tdata[159:128];
      sz = req_tdata[191:160];
      rmax = sx;
      if (sy > rmax) rmax = sy;
      if (sz > rmax) rmax = sz;
      if (rmax < HALF_UNIT) rmax = HALF_UNIT;
   end

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      q_item.center_x    = req_tdata[31:0];
      q_item.center_y    = req_tdata[63:32];
      q_item.center_z    = req_tdata[95:64];
      q_item.radius      = rmax;
      q_item.last_object = req_tlast;
   end

endmodule

// File: rtl/crsh_queue.sv
// short item queue between front end and back end
module crsh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crsh_pkg::item_type push_item,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output crsh_pkg::item_type pop_item
);
   import crsh_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   count_ff;

   assign not_full  = count_ff != CW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_item  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: rtl/crsh_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module crsh_sqrt #(
   parameter int HW = 108
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [HW-1:0]   radicand,
   output logic            done,
   output logic [HW/2-1:0] root
);
   localparam int RW = HW / 2;
   localparam int CW = $clog2(RW);

   logic [HW-1:0]   rad_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff, done_ff;
   logic [RW+1:0]   rem_sh, trial;
   logic            ge;

   always_comb begin
      rem_sh = {rem_ff[RW-1:0], rad_ff[HW-1:HW-2]};
      trial  = {root_ff, 2'b01};
      ge     = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[RW-2:0], ge};
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(RW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/crsh_back.sv
// back end: intersection sequencer, nearest-hit tracking and result register
module crsh_back #(
   parameter int FRAC_BITS = crsh_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  crsh_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  crsh_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output crsh_pkg::result_type rsp_result
);
   import crsh_pkg::*;

   localparam int HW_RAW = (2 * FRAC_BITS + 68 > 106) ? 2 * FRAC_BITS + 68 : 106;
   localparam int HW = HW_RAW + 2;
   localparam int RW = HW / 2;
   localparam int NW = RW + 2;
   localparam logic signed [31:0] LIFT =
      32'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

   back_state_type state_ff, state_in;
   step_type       step_ff, tag_ff;

   item_type           cur_ff;
   logic signed [32:0] ocx_ff, ocy_ff, ocz_ff;
   logic signed [31:0] lift_ff;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [33:0] op_a, op_b;
   logic signed [53:0] b_ff;
   logic [66:0]        oo_ff;
   logic [61:0]        rr_ff;
   logic [52:0]        bmag_ff;
   logic [HW-1:0]      p_ff, qq;
   logic signed [31:0] fbx_ff, fby_ff, fbz_ff;
   logic [NW-1:0]      t_ff;

   logic               search_open_ff, found_ff, rsp_valid_ff;
   logic [31:0]        best_ff;
   logic signed [31:0] bpx_ff, bpy_ff, bpz_ff;
   result_type         res_ff, res_in;

   logic               sqrt_start, sqrt_done;
   logic [RW-1:0]      root;
   logic signed [NW-1:0] nb, s_ext, n1, n2, num;
   logic               slot_free, closer;

   assign qq = HW'(oo_ff) << (2 * FRAC_BITS);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   crsh_sqrt #(.HW(HW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (p_ff - qq),
      .done     (sqrt_done),
      .root     (root)
   );

   always_comb begin
      nb    = -(NW'(b_ff));
      s_ext = {2'b00, root};
      n1    = nb - s_ext;
      n2    = nb + s_ext;
      num   = n1[NW-1] ? n2 : n1;
   end

   assign closer = (t_ff <= NW'(cfg.max_distance)) && (t_ff < NW'(best_ff));

   // shared multiplier operands
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         STEP_BX:  begin op_a = 34'(ocx_ff); op_b = 34'(cfg.dir_x); end
         STEP_BY:  begin op_a = 34'(ocy_ff); op_b = 34'(cfg.dir_y); end
         STEP_BZ:  begin op_a = 34'(ocz_ff); op_b = 34'(cfg.dir_z); end
         STEP_OX:  begin op_a = 34'(ocx_ff); op_b = 34'(ocx_ff); end
         STEP_OY:  begin op_a = 34'(ocy_ff); op_b = 34'(ocy_ff); end
         STEP_OZ:  begin op_a = 34'(ocz_ff); op_b = 34'(ocz_ff); end
         STEP_RR:  begin op_a = 34'(cur_ff.radius); op_b = 34'(cur_ff.radius); end
         STEP_BHH: begin op_a = {8'b0, bmag_ff[52:27]}; op_b = {8'b0, bmag_ff[52:27]}; end
         STEP_BHL: begin op_a = {8'b0, bmag_ff[52:27]}; op_b = {7'b0, bmag_ff[26:0]}; end
         STEP_BLL: begin op_a = {7'b0, bmag_ff[26:0]}; op_b = {7'b0, bmag_ff[26:0]}; end
         STEP_FX:  begin op_a = 34'(cfg.dir_x); op_b = {3'b0, cfg.max_distance}; end
         STEP_FY:  begin op_a = 34'(cfg.dir_y); op_b = {3'b0, cfg.max_distance}; end
         STEP_FZ:  begin op_a = 34'(cfg.dir_z); op_b = {3'b0, cfg.max_distance}; end
         default:  begin op_a = '0; op_b = '0; end
      endcase
      prod_in = op_a * op_b;
   end

   always_comb begin
      if (!cfg.ray_present) begin
         res_in.hit     = 1'b0;
         res_in.spawn_x = '0;
         res_in.spawn_y = '0;
         res_in.spawn_z = '0;
         res_in.hit_distance = cfg.max_distance;
      end else if (found_ff) begin
         res_in.hit     = 1'b1;
         res_in.spawn_x = bpx_ff;
         res_in.spawn_y = bpy_ff;
         res_in.spawn_z = bpz_ff;
         res_in.hit_distance = best_ff[30:0];
      end else begin
         res_in.hit     = 1'b0;
         res_in.spawn_x = fbx_ff;
         res_in.spawn_y = fby_ff;
         res_in.spawn_z = fbz_ff;
         res_in.hit_distance = cfg.max_distance;
      end
   end

   always_comb begin
      state_in   = state_ff;
      q_pop      = 1'b0;
      sqrt_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = cfg.ray_present ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL:  if (step_ff == STEP_DRAIN) state_in = ST_SUM;
         ST_SUM:  state_in = ST_CMP;
         ST_CMP: begin
            if (p_ff < qq) begin
               state_in = ST_FIN;
            end else begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: if (sqrt_done) state_in = ST_ROOT;
         ST_ROOT: state_in = num[NW-1] ? ST_FIN : ST_PICK;
         ST_PICK: state_in = ST_FIN;
         ST_FIN:  if (!cur_ff.last_object || slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         search_open_ff <= 1'b0;
         found_ff       <= 1'b0;
         best_ff        <= '0;
         bpx_ff         <= '0;
         bpy_ff         <= '0;
         bpz_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && q_valid && !search_open_ff) begin
            search_open_ff <= 1'b1;
            best_ff        <= {1'b0, cfg.max_distance};
            found_ff       <= 1'b0;
         end
         if (state_ff == ST_PICK && closer) begin
            best_ff  <= t_ff[31:0];
            found_ff <= 1'b1;
            bpx_ff   <= cur_ff.center_x;
            bpy_ff   <= lift_ff;
            bpz_ff   <= cur_ff.center_z;
         end
         if (state_ff == ST_FIN && cur_ff.last_object && slot_free) begin
            rsp_valid_ff   <= 1'b1;
            search_open_ff <= 1'b0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cur_ff  <= q_item;
               ocx_ff  <= 33'(cfg.origin_x) - 33'(q_item.center_x);
               ocy_ff  <= 33'(cfg.origin_y) - 33'(q_item.center_y);
               ocz_ff  <= 33'(cfg.origin_z) - 33'(q_item.center_z);
               lift_ff <= sat32(70'(q_item.center_y) + 70'(q_item.radius) + 70'(LIFT));
               b_ff    <= '0;
               oo_ff   <= '0;
               p_ff    <= '0;
               step_ff <= STEP_BX;
            end
         end
         ST_MUL: begin
            prod_ff <= prod_in;
            tag_ff  <= step_ff;
            if (step_ff != STEP_DRAIN) step_ff <= step_type'(step_ff + 1'b1);
            if (step_ff == STEP_RR) bmag_ff <= b_ff[53] ? 53'(-b_ff) : b_ff[52:0];
            if (step_ff != STEP_BX) begin
               case (tag_ff)
                  STEP_BX, STEP_BY, STEP_BZ: b_ff <= b_ff + 54'(prod_ff);
                  STEP_OX, STEP_OY, STEP_OZ: oo_ff <= oo_ff + prod_ff[66:0];
                  STEP_RR:  rr_ff <= prod_ff[61:0];
                  STEP_BHH: p_ff <= p_ff + (HW'(prod_ff[54:0]) << 54);
                  STEP_BHL: p_ff <= p_ff + (HW'(prod_ff[54:0]) << 28);
                  STEP_BLL: p_ff <= p_ff + HW'(prod_ff[54:0]);
                  STEP_FX:  fbx_ff <= sat32(70'(cfg.origin_x) + 70'(prod_ff >>> FRAC_BITS));
                  STEP_FY:  fby_ff <= sat32(70'(cfg.origin_y) + 70'(prod_ff >>> FRAC_BITS));
                  STEP_FZ:  fbz_ff <= sat32(70'(cfg.origin_z) + 70'(prod_ff >>> FRAC_BITS));
                  default:  ;
               endcase
            end
         end
         ST_SUM:  p_ff <= p_ff + (HW'(rr_ff) << (2 * FRAC_BITS));
         ST_ROOT: t_ff <= NW'(num >>> FRAC_BITS);
         ST_FIN:  if (cur_ff.last_object && slot_free) res_ff <= res_in;
         default: ;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

endmodule

// File: bench/closest_ray_sphere_hit_core_tb.sv
// self-checking bench for the closest ray/sphere hit core: directed table, then random scenes
module closest_ray_sphere_hit_core_tb;
   import crsh_pkg::*;

   localparam int FB = 16;
   localparam longint ONE = 64'sd1 << FB;
   localparam longint LIFT = ((64'sd5 << FB) + 50) / 100;
   localparam int SETTLE = 400;

   typedef struct {
      logic signed [31:0] cx, cy, cz, sx, sy, sz;
      bit                 last;
      bit                 typed;
      result_type         want;
   } row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   closest_ray_sphere_hit_core dut (.*);

   // predictor copy of the ray registers and the search state
   cfg_type     ray;
   logic [31:0] best_dist;
   bit          found_hit;
   bit          search_busy;
   logic signed [31:0] best_x, best_y, best_z;

   result_type spawn_due[$];
   int errors;
   int send_idle;
   int recv_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // exact sphere test; returns the distance in t when hit within max_distance
   function automatic bit sphere_distance(input logic signed [31:0] c[3], input longint r,
                                          output longint t);
      logic signed [127:0] oc[3];
      logic signed [127:0] dir[3];
      logic signed [127:0] b, oo, h, s, cand, num;
      oc[0] = $signed(ray.origin_x) - c[0];
      oc[1] = $signed(ray.origin_y) - c[1];
      oc[2] = $signed(ray.origin_z) - c[2];
      dir[0] = $signed(ray.dir_x);
      dir[1] = $signed(ray.dir_y);
      dir[2] = $signed(ray.dir_z);
      b = 0;
      oo = 0;
      t = 0;
      for (int i = 0; i < 3; i++) begin
         b += oc[i] * dir[i];
         oo += oc[i] * oc[i];
      end
      h = b * b + ((128'(r) * r) <<< (2 * FB)) - (oo <<< (2 * FB));
      if (h < 0) return 0;
      s = 0;
      for (int k = 60; k >= 0; k--) begin
         cand = s | (128'sd1 << k);
         if (cand * cand <= h) s = cand;
      end
      num = -b - s;
      if (num < 0) num = -b + s;
      if (num < 0) return 0;
      num = num >>> FB;
      if (num > $signed({97'd0, ray.max_distance})) return 0;
      t = num;
      return 1;
   endfunction

   function automatic bit predict_search(input logic signed [31:0] c[3],
                                         input logic signed [31:0] sc[3], input bit last,
                                         output result_type res);
      longint r, t, md;
      res = '0;
      if (!search_busy) begin
         search_busy = 1;
         best_dist = {1'b0, ray.max_distance};
         found_hit = 0;
      end
      if (ray.ray_present) begin
         r = sc[0];
         if (sc[1] > r) r = sc[1];
         if (sc[2] > r) r = sc[2];
         if (r < ONE / 2) r = ONE / 2;
         if (sphere_distance(c, r, t) && t < longint'(best_dist)) begin
            best_dist = t[31:0];
            found_hit = 1;
            best_x = c[0];
            best_y = clamp32(longint'(c[1]) + r + LIFT);
            best_z = c[2];
         end
      end
      if (!last) return 0;
      search_busy = 0;
      md = longint'(ray.max_distance);
      res.hit_distance = ray.max_distance;
      if (!ray.ray_present) begin
         res.hit = 0;
      end else if (found_hit) begin
         res = '{1'b1, best_x, best_y, best_z, best_dist[30:0]};
      end else begin
         res.spawn_x = clamp32(longint'(ray.origin_x) + ((longint'(ray.dir_x) * md) >>> FB));
         res.spawn_y = clamp32(longint'(ray.origin_y) + ((longint'(ray.dir_y) * md) >>> FB));
         res.spawn_z = clamp32(longint'(ray.origin_z) + ((longint'(ray.dir_z) * md) >>> FB));
      end
      return 1;
   endfunction

   task automatic report(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (spawn_due.size() == 0) begin
            report("unexpected item", 1, 0);
         end else begin
            want = spawn_due.pop_front();
            if (rsp_tuser[0] !== want.hit) report("hit", rsp_tuser[0], want.hit);
            if (rsp_tdata[31:0] !== want.spawn_x)
               report("spawn_x", $signed(rsp_tdata[31:0]), want.spawn_x);
            if (rsp_tdata[63:32] !== want.spawn_y)
               report("spawn_y", $signed(rsp_tdata[63:32]), want.spawn_y);
            if (rsp_tdata[95:64] !== want.spawn_z)
               report("spawn_z", $signed(rsp_tdata[95:64]), want.spawn_z);
            if (rsp_tdata[126:96] !== want.hit_distance)
               report("hit_distance", rsp_tdata[126:96], want.hit_distance);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ORIGIN_X:    ray.origin_x = value;
         REG_ORIGIN_Y:    ray.origin_y = value;
         REG_ORIGIN_Z:    ray.origin_z = value;
         REG_DIR_X:       ray.dir_x = value[17:0];
         REG_DIR_Y:       ray.dir_y = value[17:0];
         REG_DIR_Z:       ray.dir_z = value[17:0];
         REG_MAX_DIST:    ray.max_distance = value[30:0];
         REG_RAY_PRESENT: ray.ray_present = value[0];
         default: ;
      endcase
      // wait idle so the next write starts on a fresh edge
      @(posedge clock);
   endtask

   task automatic send_object(input logic signed [31:0] c[3], input logic signed [31:0] sc[3],
                              input bit last, input bit typed, input result_type want);
      result_type res;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {sc[2], sc[1], sc[0], c[2], c[1], c[0]};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (predict_search(c, sc, last, res)) spawn_due.push_back(typed ? want : res);
   endtask

   // drain all results, then give the back end time to finish objects without a result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (spawn_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [31:0] to_fix(input real v);
      if (v > 2147483647.0) return 32'sh7fffffff;
      if (v < -2147483648.0) return 32'sh80000000;
      return $rtoi(v);
   endfunction

   function automatic real rand_real(input real lo, input real hi);
      return lo + (hi - lo) * ($urandom_range(1000000) / 1000000.0);
   endfunction

   task automatic random_config();
      real dx, dy, dz, n;
      logic [31:0] oval[3];
      logic [31:0] dval[3];
      logic [31:0] md;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(9))
            0: oval[i] = $urandom;
            1: oval[i] = $urandom_range(1) ? 32'h7fff0000 : 32'h80010000;
            default: oval[i] = to_fix(rand_real(-8.0, 8.0) * ONE);
         endcase
      end
      dx = rand_real(-1.0, 1.0);
      dy = rand_real(-1.0, 1.0);
      dz = rand_real(-1.0, 1.0);
      n = $sqrt(dx * dx + dy * dy + dz * dz) + 1.0e-9;
      dval[0] = to_fix(dx / n * ONE);
      dval[1] = to_fix(dy / n * ONE);
      dval[2] = to_fix(dz / n * ONE);
      case ($urandom_range(9))
         0: for (int i = 0; i < 3; i++) dval[i] = $urandom;
         1: begin
            dval = '{0, 0, 0};
            dval[$urandom_range(2)] = $urandom_range(1) ? 32'h10000 : 32'hffff0000;
         end
         default: ;
      endcase
      case ($urandom_range(19))
         0: md = 0;
         1: md = 32'h7fffffff;
         2: md = $urandom;
         default: md = $urandom_range(40 * ONE);
      endcase
      csr_write(REG_ORIGIN_X, oval[0]);
      csr_write(REG_ORIGIN_Y, oval[1]);
      csr_write(REG_ORIGIN_Z, oval[2]);
      csr_write(REG_DIR_X, dval[0]);
      csr_write(REG_DIR_Y, dval[1]);
      csr_write(REG_DIR_Z, dval[2]);
      csr_write(REG_MAX_DIST, md);
      csr_write(REG_RAY_PRESENT, ($urandom_range(11) != 0));
   endtask

   task automatic random_object(input bit last);
      logic signed [31:0] c[3];
      logic signed [31:0] sc[3];
      real t, spread;
      real o[3];
      real d[3];
      o = '{real'(ray.origin_x), real'(ray.origin_y), real'(ray.origin_z)};
      d = '{real'(ray.dir_x) / ONE, real'(ray.dir_y) / ONE, real'(ray.dir_z) / ONE};
      if ($urandom_range(9) < 7) begin
         // sphere placed near the ray
         t = rand_real(-2.0, 1.3 * real'(ray.max_distance) / ONE + 1.0) * ONE;
         spread = rand_real(0.0, 1.5) * ONE;
         for (int i = 0; i < 3; i++) begin
            c[i] = to_fix(o[i] + d[i] * t + rand_real(-spread, spread));
            sc[i] = to_fix(rand_real(-0.5, 2.0) * ONE);
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            c[i] = $urandom;
            sc[i] = $urandom;
         end
      end
      send_object(c, sc, last, 0, '0);
   endtask

   row_type plan[12];

   initial begin
      logic signed [31:0] c[3];
      logic signed [31:0] sc[3];
      int sent;
      int len;
      plan = '{
         '{0, 0, 2 * ONE, ONE, ONE, ONE, 1, 1, '{1, 0, 68813, 131072, 65536}},
         '{0, 100 * ONE, 0, ONE, ONE, ONE, 1, 1, '{0, 0, 0, 327680, 327680}},
         '{0, 0, 3 * ONE, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1,
           '{1, 0, 36045, 196608, 163840}},
         '{0, 0, -3 * ONE, ONE, ONE, ONE, 1, 1, '{0, 0, 0, 327680, 327680}},
         '{0, 0, 0, 32'sh7fffffff, 0, 0, 1, 0, '0},
         '{32'sh80000000, 32'sh80000000, 32'sh80000000, ONE, ONE, ONE, 0, 0, '0},
         '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
           32'sh7fffffff, 1, 0, '0},
         '{0, 0, 4 * ONE, ONE, ONE, ONE, 0, 0, '0},
         '{0, 0, 2 * ONE, ONE / 2, ONE / 2, ONE / 2, 0, 0, '0},
         '{0, 0, 2 * ONE, 0, ONE / 2, 0, 1, 0, '0},
         '{0, 0, 10 * ONE, ONE, ONE, ONE, 1, 1, '{0, 0, 0, 327680, 327680}},
         '{0, ONE / 4, ONE + ONE / 2, 0, 0, ONE / 4, 1, 0, '0}
      };
      ray = '{0, 0, 0, 0, 0, 18'sh10000, 31'd327680, 1'b1};
      best_dist = 0;
      found_hit = 0;
      search_busy = 0;
      best_x = 0;
      best_y = 0;
      best_z = 0;
      errors = 0;
      send_idle = 28;
      recv_idle = 87;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         c = '{plan[i].cx, plan[i].cy, plan[i].cz};
         sc = '{plan[i].sx, plan[i].sy, plan[i].sz};
         send_object(c, sc, plan[i].last, plan[i].typed, plan[i].want);
      end
      settle();

      sent = 0;
      while (sent < 1700) begin
         if (sent > 1130) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (sent > 570) begin
            send_idle = 87;
            recv_idle = 28;
         end
         random_config();
         len = $urandom_range(1, 8);
         // some searches stay open across a register change
         for (int k = 0; k < len; k++) begin
            random_object(k == len - 1 && $urandom_range(4) != 0);
            sent++;
         end
         settle();
      end

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/crsh_pkg.sv
rtl/crsh_front.sv
rtl/crsh_queue.sv
rtl/crsh_sqrt.sv
rtl/crsh_back.sv
rtl/closest_ray_sphere_hit_core.sv
bench/closest_ray_sphere_hit_core_tb.sv
